FILE: rtl/core/rau_pkg.sv
`default_nettype none

package rau_pkg;

	localparam int OPERAND_BITS = 16;
	localparam int DEN_IN_BITS  = OPERAND_BITS - 1;
	localparam int PROD_BITS    = 2 * OPERAND_BITS;
	localparam int SUM_BITS     = PROD_BITS + 1;
	localparam int MAG_BITS     = PROD_BITS;
	localparam int SHIFT_BITS   = $clog2(MAG_BITS);
	localparam int CNT_BITS     = $clog2(MAG_BITS + 1);

	localparam int NUM_OUT_BITS = 33;
	localparam int DEN_OUT_BITS = 31;
	localparam int NUM_WIDE_BITS = (MAG_BITS + 1 > NUM_OUT_BITS) ? MAG_BITS + 1 : NUM_OUT_BITS;
	localparam int DEN_WIDE_BITS = (MAG_BITS > DEN_OUT_BITS) ? MAG_BITS : DEN_OUT_BITS;

	localparam int ACTION_BITS = 3;
	localparam int FLAG_BITS   = 3;

	localparam int LHS_NUM_LO = 0;
	localparam int LHS_DEN_LO = LHS_NUM_LO + OPERAND_BITS;
	localparam int RHS_NUM_LO = LHS_DEN_LO + DEN_IN_BITS;
	localparam int RHS_DEN_LO = RHS_NUM_LO + OPERAND_BITS;
	localparam int IN_FIELD_BITS = RHS_DEN_LO + DEN_IN_BITS;
	localparam int S_TDATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;

	localparam int OUT_FIELD_BITS = NUM_OUT_BITS + DEN_OUT_BITS;
	localparam int M_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_ADD = 3'd0,
		ACT_SUB = 3'd1,
		ACT_MUL = 3'd2,
		ACT_DIV = 3'd3,
		ACT_CMP = 3'd4
	} action_t;

	typedef logic [MAG_BITS-1:0] mag_t;

endpackage

`default_nettype wire

FILE: rtl/core/rau_gcd.sv
`default_nettype none

// binary gcd, both operands nonzero
module rau_gcd (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire rau_pkg::mag_t    a,
	input  wire rau_pkg::mag_t    b,
	output logic                  done,
	output rau_pkg::mag_t         g
);

	typedef enum logic [1:0] {
		G_IDLE,
		G_STRIP,
		G_REDUCE
	} gstate_t;

	gstate_t                           state_q;
	rau_pkg::mag_t                     a_q;
	rau_pkg::mag_t                     b_q;
	logic [rau_pkg::SHIFT_BITS-1:0]    k_q;
	logic                              done_q;
	rau_pkg::mag_t                     g_q;

	logic                              a_gt;
	rau_pkg::mag_t                     diff;

	assign a_gt = a_q > b_q;
	assign diff = a_gt ? (a_q - b_q) : (b_q - a_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				G_IDLE: begin
					if (start) begin
						a_q     <= a;
						b_q     <= b;
						k_q     <= '0;
						state_q <= G_STRIP;
					end
				end
				G_STRIP: begin
					if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= G_REDUCE;
					end
				end
				G_REDUCE: begin
					if (a_q == b_q) begin
						g_q     <= a_q << k_q;
						done_q  <= 1'b1;
						state_q <= G_IDLE;
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (a_gt) begin
						a_q <= diff >> 1;
					end else begin
						b_q <= diff >> 1;
					end
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign g    = g_q;

endmodule

`default_nettype wire

FILE: rtl/core/rau_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module rau_div (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire rau_pkg::mag_t    dividend,
	input  wire rau_pkg::mag_t    divisor,
	output logic                  done,
	output rau_pkg::mag_t         quotient
);

	typedef enum logic {
		D_IDLE,
		D_RUN
	} dstate_t;

	dstate_t                         state_q;
	rau_pkg::mag_t                   rem_q;
	rau_pkg::mag_t                   quo_q;
	rau_pkg::mag_t                   dvs_q;
	logic [rau_pkg::CNT_BITS-1:0]    cnt_q;
	logic                            done_q;

	logic [rau_pkg::MAG_BITS:0]      shifted;
	logic [rau_pkg::MAG_BITS:0]      trial;

	assign shifted = {rem_q, quo_q[rau_pkg::MAG_BITS-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						rem_q   <= '0;
						quo_q   <= dividend;
						dvs_q   <= divisor;
						cnt_q   <= rau_pkg::CNT_BITS'(rau_pkg::MAG_BITS);
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (!trial[rau_pkg::MAG_BITS]) begin
						rem_q <= trial[rau_pkg::MAG_BITS-1:0];
					end else begin
						rem_q <= shifted[rau_pkg::MAG_BITS-1:0];
					end
					quo_q <= {quo_q[rau_pkg::MAG_BITS-2:0], ~trial[rau_pkg::MAG_BITS]};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == rau_pkg::CNT_BITS'(1)) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/rational_arithmetic_unit.sv
`default_nettype none

// channel   dir  tdata (low bit up)                          tuser
// s_axis    in   lhs_num, lhs_den, rhs_num, rhs_den, pad     action
// m_axis    out  res_num, res_den                            is_less, is_equal, div_by_zero
//
// An item runs from transfer to transfer through these states: a divide by zero or an
// unused action goes straight to FIN, compare ends after MUL0, MUL1, MUL2 and FORM, a
// zero result after SIGN, and otherwise the item passes MUL0 to MUL2, the setup states
// FORM and SIGN, a binary gcd of one step per cycle and two restoring divisions.
// s_axis_tready is high only while the sequencer is idle; a finished result waits in
// the output register, and m_axis_tready low stalls the sequencer only when a second
// result is ready. Reset clears control state.
module rational_arithmetic_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire [rau_pkg::S_TDATA_BITS-1:0]     s_axis_tdata,  // lhs_num, lhs_den, rhs_num, rhs_den
	input  wire [rau_pkg::ACTION_BITS-1:0]      s_axis_tuser,  // action
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	output logic [rau_pkg::M_TDATA_BITS-1:0]    m_axis_tdata,  // res_num, res_den
	output logic [rau_pkg::FLAG_BITS-1:0]       m_axis_tuser   // is_less, is_equal, div_by_zero
);

	localparam int OB = rau_pkg::OPERAND_BITS;
	localparam int DB = rau_pkg::DEN_IN_BITS;
	localparam int PB = rau_pkg::PROD_BITS;
	localparam int SB = rau_pkg::SUM_BITS;
	localparam int MB = rau_pkg::MAG_BITS;
	localparam int NO = rau_pkg::NUM_OUT_BITS;
	localparam int DO = rau_pkg::DEN_OUT_BITS;
	localparam int NW = rau_pkg::NUM_WIDE_BITS;
	localparam int DW = rau_pkg::DEN_WIDE_BITS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_FORM,
		ST_SIGN,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_FIN
	} state_t;

	state_t                    state_q;
	rau_pkg::action_t          act_q;
	logic signed [OB-1:0]      an_q, ad_q, bn_q, bd_q;
	logic signed [PB-1:0]      x_q, y_q, d_q;
	logic signed [SB-1:0]      n_q;
	logic signed [PB-1:0]      dn_q;
	rau_pkg::mag_t             nmag_q, dmag_q, g_q, qn_q;
	logic                      neg_q;
	logic [NO-1:0]             rn_q;
	logic [DO-1:0]             rd_q;
	logic                      lt_q, eq_q, dz_q;

	logic                      out_valid_q;
	logic [NO-1:0]             out_num_q;
	logic [DO-1:0]             out_den_q;
	logic                      out_lt_q, out_eq_q, out_dz_q;

	logic signed [OB-1:0]      in_an, in_ad, in_bn, in_bd;
	logic [DB-1:0]             lhs_den_f, rhs_den_f;
	logic signed [OB-1:0]      mul_a, mul_b;
	logic signed [PB-1:0]      mul_p;
	logic signed [SB-1:0]      n_abs;
	logic signed [PB-1:0]      d_abs;
	logic                      gcd_start, gcd_done;
	rau_pkg::mag_t             gcd_g;
	logic                      div_start, div_done;
	rau_pkg::mag_t             div_dividend, div_divisor, div_q;
	logic signed [NW-1:0]      num_wide;
	logic [DW-1:0]             den_wide;
	logic                      out_free;

	assign lhs_den_f = s_axis_tdata[rau_pkg::LHS_DEN_LO +: DB];
	assign rhs_den_f = s_axis_tdata[rau_pkg::RHS_DEN_LO +: DB];
	assign in_an = s_axis_tdata[rau_pkg::LHS_NUM_LO +: OB];
	assign in_bn = s_axis_tdata[rau_pkg::RHS_NUM_LO +: OB];
	assign in_ad = (lhs_den_f == '0) ? OB'(1) : {1'b0, lhs_den_f};
	assign in_bd = (rhs_den_f == '0) ? OB'(1) : {1'b0, rhs_den_f};

	always_comb begin
		mul_a = ad_q;
		mul_b = bd_q;
		case (state_q)
			ST_MUL0: begin
				mul_a = an_q;
				mul_b = (act_q == rau_pkg::ACT_MUL) ? bn_q : bd_q;
			end
			ST_MUL1: begin
				mul_a = ad_q;
				mul_b = bn_q;
			end
			default: begin
				mul_a = ad_q;
				mul_b = bd_q;
			end
		endcase
	end

	assign mul_p = PB'(mul_a) * PB'(mul_b);

	assign n_abs = n_q[SB-1] ? -n_q : n_q;
	assign d_abs = dn_q[PB-1] ? -dn_q : dn_q;

	assign gcd_start = (state_q == ST_SIGN) && (n_q != '0);

	assign div_start    = ((state_q == ST_GCD) && gcd_done) ||
	                      ((state_q == ST_DIVN) && div_done);
	assign div_dividend = (state_q == ST_GCD) ? nmag_q : dmag_q;
	assign div_divisor  = (state_q == ST_GCD) ? gcd_g : g_q;

	assign num_wide = neg_q ? -NW'(qn_q) : NW'(qn_q);
	assign den_wide = DW'(div_q);

	assign out_free = !out_valid_q || m_axis_tready;

	rau_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a      (n_abs[MB-1:0]),
		.b      (d_abs[MB-1:0]),
		.done   (gcd_done),
		.g      (gcd_g)
	);

	rau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						act_q <= rau_pkg::action_t'(s_axis_tuser);
						an_q  <= in_an;
						ad_q  <= in_ad;
						bn_q  <= in_bn;
						bd_q  <= in_bd;
						rn_q  <= '0;
						rd_q  <= DO'(1);
						lt_q  <= 1'b0;
						eq_q  <= 1'b0;
						dz_q  <= 1'b0;
						unique case (s_axis_tuser) inside
							rau_pkg::ACT_ADD, rau_pkg::ACT_SUB, rau_pkg::ACT_MUL,
							rau_pkg::ACT_CMP: begin
								state_q <= ST_MUL0;
							end
							rau_pkg::ACT_DIV: begin
								if (in_bn == '0) begin
									dz_q    <= 1'b1;
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_MUL0;
								end
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_MUL0: begin
					x_q     <= mul_p;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					y_q     <= mul_p;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					d_q     <= mul_p;
					state_q <= ST_FORM;
				end
				ST_FORM: begin
					dn_q    <= (act_q == rau_pkg::ACT_DIV) ? y_q : d_q;
					state_q <= ST_SIGN;
					case (act_q)
						rau_pkg::ACT_ADD: n_q <= SB'(x_q) + SB'(y_q);
						rau_pkg::ACT_SUB: n_q <= SB'(x_q) - SB'(y_q);
						rau_pkg::ACT_CMP: begin
							n_q     <= SB'(x_q);
							lt_q    <= x_q < y_q;
							eq_q    <= x_q == y_q;
							state_q <= ST_FIN;
						end
						default: n_q <= SB'(x_q);
					endcase
				end
				ST_SIGN: begin
					nmag_q <= n_abs[MB-1:0];
					dmag_q <= d_abs[MB-1:0];
					neg_q  <= n_q[SB-1] ^ dn_q[PB-1];
					if (n_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					if (gcd_done) begin
						g_q     <= gcd_g;
						state_q <= ST_DIVN;
					end
				end
				ST_DIVN: begin
					if (div_done) begin
						qn_q    <= div_q;
						state_q <= ST_DIVD;
					end
				end
				ST_DIVD: begin
					if (div_done) begin
						rn_q    <= num_wide[NO-1:0];
						rd_q    <= den_wide[DO-1:0];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_num_q   <= rn_q;
						out_den_q   <= rd_q;
						out_lt_q    <= lt_q;
						out_eq_q    <= eq_q;
						out_dz_q    <= dz_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = rau_pkg::M_TDATA_BITS'({out_den_q, out_num_q});
	assign m_axis_tuser  = {out_dz_q, out_eq_q, out_lt_q};

endmodule

`default_nettype wire
